// File: sv/uart_pwm_command_parser_top_defines.svh
// Assertion macros shared by the uart_pwm_command_parser checker.
// No dependencies; the caller passes clock and reset explicitly.
`ifndef UART_PWM_COMMAND_PARSER_TOP_DEFINES_SVH
`define UART_PWM_COMMAND_PARSER_TOP_DEFINES_SVH

// condition now implies condition in the next cycle, outside reset
`define UPCP_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("upcp assertion failed");

// condition holds at every edge outside reset
`define UPCP_ASSERT_NOW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("upcp assertion failed");

// implication in the next cycle, also checked through reset
`define UPCP_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("upcp assertion failed");

`endif

// File: sv/upcp_pkg.sv
// Package for the uart_pwm_command_parser: character codes, limits, command type.
// No dependencies.
`timescale 1ns / 1ps

package upcp_pkg;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [3:0] MAX_DIGITS = 4'd15;
  localparam logic [8:0] VALUE_SAT  = 9'd256;
  localparam logic [7:0] DUTY_MAX   = 8'd255;
  localparam logic [1:0] NO_CHANNEL = 2'd0;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SELECT,
    CMD_DIGIT,
    CMD_TERM
  } cmd_kind_t;

  // arg: channel code 1..3 for CMD_SELECT, digit value for CMD_DIGIT
  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] arg;
  } cmd_t;

endpackage

// File: sv/uart_pwm_command_parser_top.sv
// Top level of the uart_pwm_command_parser.
// Depends on upcp_pkg, upcp_front, upcp_queue, upcp_back.
//
// Parses ASCII command bytes ('A'/'B'/'C' selects a channel, decimal digits
// build a value, space/CR/LF ends it) and returns one transaction per finished
// command with the channel and duty clamped to 255. One byte is taken every
// cycle while rx_stall is low; the terminating byte passes through the two-entry
// command queue and then the output register, which raises out_valid. The queue
// sits between the byte classifier and the state/output stage, so rx_stall rises
// only after two commands back up behind a stalled output register.
`timescale 1ns / 1ps

module uart_pwm_command_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] pwm_channel,
  output logic [7:0] duty
);

  logic           q_full;
  logic           push;
  upcp_pkg::cmd_t push_cmd;
  logic           q_valid;
  upcp_pkg::cmd_t q_cmd;
  logic           pop;

  upcp_front u_front (
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_stall (rx_stall),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  upcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  upcp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_channel (pwm_channel),
    .duty        (duty)
  );

endmodule

// File: sv/upcp_front.sv
// Front end: accepts received bytes and classifies them into commands.
// Depends on upcp_pkg.
`timescale 1ns / 1ps

module upcp_front (
  input  logic           rx_valid,
  input  logic [7:0]     rx_byte,
  output logic           rx_stall,
  input  logic           q_full,
  output logic           push,
  output upcp_pkg::cmd_t push_cmd
);

  upcp_pkg::cmd_t cmd;

  always_comb begin
    cmd.kind = upcp_pkg::CMD_NONE;
    cmd.arg  = 4'd0;
    if (rx_byte == upcp_pkg::CHAR_A || rx_byte == upcp_pkg::CHAR_B ||
        rx_byte == upcp_pkg::CHAR_C) begin
      cmd.kind = upcp_pkg::CMD_SELECT;
      cmd.arg  = 4'(rx_byte - upcp_pkg::CHAR_A + 8'd1);
    end else if (rx_byte == upcp_pkg::CHAR_SPACE || rx_byte == upcp_pkg::CHAR_CR ||
                 rx_byte == upcp_pkg::CHAR_LF) begin
      cmd.kind = upcp_pkg::CMD_TERM;
    end else if (rx_byte >= upcp_pkg::CHAR_0 && rx_byte <= upcp_pkg::CHAR_9) begin
      cmd.kind = upcp_pkg::CMD_DIGIT;
      cmd.arg  = 4'(rx_byte - upcp_pkg::CHAR_0);
    end
  end

  // other bytes are taken and dropped here
  assign rx_stall = q_full;
  assign push     = rx_valid && !q_full && (cmd.kind != upcp_pkg::CMD_NONE);
  assign push_cmd = cmd;

endmodule

// File: sv/upcp_queue.sv
// Two-entry command queue between front end and back end.
// Depends on upcp_pkg.
`timescale 1ns / 1ps

module upcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  upcp_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           q_valid,
  output upcp_pkg::cmd_t q_cmd,
  input  logic           pop
);

  upcp_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: sv/upcp_back.sv
// Back end: parser state (channel, digit count, saturating accumulator) and
// the output register. Depends on upcp_pkg.
`timescale 1ns / 1ps

module upcp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  upcp_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     pwm_channel,
  output logic [7:0]     duty
);

  logic [1:0]  sel_ch;
  logic [1:0]  sel_ch_next;
  logic [3:0]  digit_count;
  logic [3:0]  digit_count_next;
  logic [8:0]  value_accum;
  logic [8:0]  value_accum_next;
  logic [11:0] value_ext;
  logic        out_free;
  logic        emit;

  assign out_free  = !out_valid || !out_stall;
  assign pop       = q_valid && out_free;
  assign value_ext = 12'(value_accum) * 12'd10 + 12'(q_cmd.arg);

  always_comb begin
    sel_ch_next      = sel_ch;
    digit_count_next = digit_count;
    value_accum_next = value_accum;
    emit             = 1'b0;
    if (pop) begin
      case (q_cmd.kind)
        upcp_pkg::CMD_SELECT: begin
          sel_ch_next      = q_cmd.arg[1:0];
          digit_count_next = 4'd0;
        end
        upcp_pkg::CMD_DIGIT: begin
          if (digit_count < upcp_pkg::MAX_DIGITS) begin
            if (digit_count == 4'd0) begin
              value_accum_next = 9'(q_cmd.arg);
            end else if (value_ext > 12'(upcp_pkg::VALUE_SAT)) begin
              value_accum_next = upcp_pkg::VALUE_SAT;
            end else begin
              value_accum_next = value_ext[8:0];
            end
            digit_count_next = digit_count + 4'd1;
          end
        end
        upcp_pkg::CMD_TERM: begin
          if (digit_count != 4'd0) begin
            digit_count_next = 4'd0;
            if (sel_ch != upcp_pkg::NO_CHANNEL) begin
              emit        = 1'b1;
              sel_ch_next = upcp_pkg::NO_CHANNEL;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_ch      <= upcp_pkg::NO_CHANNEL;
      digit_count <= 4'd0;
      value_accum <= 9'd0;
      out_valid   <= 1'b0;
    end else begin
      sel_ch      <= sel_ch_next;
      digit_count <= digit_count_next;
      value_accum <= value_accum_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pwm_channel <= sel_ch - 2'd1;
      duty        <= (value_accum > 9'(upcp_pkg::DUTY_MAX)) ? upcp_pkg::DUTY_MAX
                                                             : value_accum[7:0];
    end
  end

endmodule

// File: sv/upcp_checker.sv
// Port-level checker for uart_pwm_command_parser_top, bound to the top level.
// Depends on uart_pwm_command_parser_top_defines.svh.
`timescale 1ns / 1ps
`include "uart_pwm_command_parser_top_defines.svh"

module upcp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] pwm_channel,
  input logic [7:0] duty
);

  `UPCP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)
  `UPCP_ASSERT_NOW(a_channel_range, clk, rst, !out_valid || pwm_channel != 2'd3)
  `UPCP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `UPCP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
                    $stable(pwm_channel) && $stable(duty))

endmodule

bind uart_pwm_command_parser_top upcp_checker u_upcp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pwm_channel (pwm_channel),
  .duty        (duty)
);

// File: verif/uart_pwm_command_parser_top_tb.sv
// Self-checking testbench for uart_pwm_command_parser_top: byte driver, result monitor,
// built-in parser predictor and random idle/stall phases with one long output hold-off.
// Depends on upcp_pkg and uart_pwm_command_parser_top.
`timescale 1ns / 1ps

module uart_pwm_command_parser_top_tb;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [1:0] ch;
    logic [7:0] duty;
  } pwm_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] pwm_channel;
  logic [7:0] duty;

  logic [7:0] byte_q[$];
  pwm_cmd_t   duty_q[$];

  // predictor state
  logic [1:0] cur_ch = upcp_pkg::NO_CHANNEL;
  logic [3:0] num_digits = '0;
  logic [8:0] num_value = '0;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  fed_cnt = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  rx_taken = 1'b0;

  uart_pwm_command_parser_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_channel (pwm_channel),
    .duty        (duty)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int v;
    pwm_cmd_t cmd;
    if (b == upcp_pkg::CHAR_A || b == upcp_pkg::CHAR_B || b == upcp_pkg::CHAR_C) begin
      cur_ch = 2'(b - upcp_pkg::CHAR_A) + 2'd1;
      num_digits = '0;
    end else if (b == upcp_pkg::CHAR_SPACE || b == upcp_pkg::CHAR_CR ||
                 b == upcp_pkg::CHAR_LF) begin
      if (num_digits != 0) begin
        num_digits = '0;
        if (cur_ch != upcp_pkg::NO_CHANNEL) begin
          cmd.ch = cur_ch - 2'd1;
          cmd.duty = (num_value > 9'(upcp_pkg::DUTY_MAX)) ? upcp_pkg::DUTY_MAX
                                                           : num_value[7:0];
          duty_q.push_back(cmd);
          cur_ch = upcp_pkg::NO_CHANNEL;
        end
      end
    end else if (b >= upcp_pkg::CHAR_0 && b <= upcp_pkg::CHAR_9) begin
      if (num_digits < upcp_pkg::MAX_DIGITS) begin
        if (num_digits == 0) begin
          num_value = 9'(b - upcp_pkg::CHAR_0);
        end else begin
          v = int'(num_value) * 10 + int'(b - upcp_pkg::CHAR_0);
          num_value = (v > int'(upcp_pkg::VALUE_SAT)) ? upcp_pkg::VALUE_SAT : 9'(v);
        end
        num_digits = num_digits + 4'd1;
      end
    end
  endtask

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_taken) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rx_valid <= 1'b1;
        rx_byte <= byte_q.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // output stall, with the long hold-off counted here
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
    if (hold_left != 0) hold_left--;
  end

  // input transaction capture and prediction
  always @(posedge clk) begin
    rx_taken = !rst && rx_valid && !rx_stall;
    if (rx_taken) parse_byte(rx_byte);
  end

  // result monitor
  always @(posedge clk) begin
    pwm_cmd_t exp_cmd;
    if (!rst && out_valid && !out_stall) begin
      if (duty_q.size() == 0) begin
        flag_error($sformatf("unexpected result ch=%0d duty=%0d", pwm_channel, duty));
      end else begin
        exp_cmd = duty_q.pop_front();
        if (pwm_channel !== exp_cmd.ch)
          flag_error($sformatf("pwm_channel %0d, expected %0d", pwm_channel, exp_cmd.ch));
        if (duty !== exp_cmd.duty)
          flag_error($sformatf("duty %0d, expected %0d", duty, exp_cmd.duty));
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction in %0d cycles", IDLE_LIMIT);
        $display("** uart_pwm_command_parser_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    if (b == upcp_pkg::CHAR_A || b == upcp_pkg::CHAR_B || b == upcp_pkg::CHAR_C ||
        b == upcp_pkg::CHAR_SPACE || b == upcp_pkg::CHAR_CR || b == upcp_pkg::CHAR_LF ||
        (b >= upcp_pkg::CHAR_0 && b <= upcp_pkg::CHAR_9))
      fed_cnt++;
  endtask

  task automatic push_letter();
    case ($urandom_range(0, 2))
      0: push_byte(upcp_pkg::CHAR_A);
      1: push_byte(upcp_pkg::CHAR_B);
      default: push_byte(upcp_pkg::CHAR_C);
    endcase
  endtask

  task automatic push_term();
    case ($urandom_range(0, 2))
      0: push_byte(upcp_pkg::CHAR_SPACE);
      1: push_byte(upcp_pkg::CHAR_CR);
      default: push_byte(upcp_pkg::CHAR_LF);
    endcase
  endtask

  task automatic push_number();
    int val;
    int zeros;
    int extra;
    int dg[$];
    case ($urandom_range(0, 3))
      0: val = $urandom_range(0, 9);
      1: val = $urandom_range(0, 99);
      2: val = $urandom_range(240, 270);
      default: val = $urandom_range(0, 999);
    endcase
    zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 0;
    extra = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 4) : 0;
    do begin
      dg.push_front(val % 10);
      val = val / 10;
    end while (val != 0);
    repeat (zeros) push_byte(upcp_pkg::CHAR_0);
    foreach (dg[i]) push_byte(upcp_pkg::CHAR_0 + 8'(dg[i]));
    repeat (extra) push_byte(upcp_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      push_letter();
      push_number();
      push_term();
      if ($urandom_range(0, 7) == 0) push_term();
    end else if (r < 85) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (r < 92) begin
      push_number();
      push_term();
    end else if (r < 96) begin
      push_letter();
      push_term();
    end else begin
      push_letter();
      push_number();
      push_letter();
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n, input bit hold);
    int target;
    send_idle_pct = idle;
    stall_pct = stall;
    target = fed_cnt + n;
    while (fed_cnt < target) push_random_cmd();
    if (hold) hold_req = 1'b1;
    while (byte_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // channel select, clamp, overflow, terminators, no-channel and reselect cases
    push_byte(upcp_pkg::CHAR_A); push_byte(upcp_pkg::CHAR_0);
    push_byte(upcp_pkg::CHAR_SPACE);
    push_byte(upcp_pkg::CHAR_B); push_byte(upcp_pkg::CHAR_0 + 8'd2);
    push_byte(upcp_pkg::CHAR_0 + 8'd5); push_byte(upcp_pkg::CHAR_0 + 8'd5);
    push_byte(upcp_pkg::CHAR_CR);
    push_byte(upcp_pkg::CHAR_C); push_byte(upcp_pkg::CHAR_0 + 8'd2);
    push_byte(upcp_pkg::CHAR_0 + 8'd5); push_byte(upcp_pkg::CHAR_0 + 8'd6);
    push_byte(upcp_pkg::CHAR_LF);
    push_byte(upcp_pkg::CHAR_0 + 8'd7); push_byte(upcp_pkg::CHAR_SPACE);
    push_byte(upcp_pkg::CHAR_A); push_byte(upcp_pkg::CHAR_SPACE);
    push_byte(upcp_pkg::CHAR_0 + 8'd1); push_byte(upcp_pkg::CHAR_0 + 8'd2);
    push_byte(upcp_pkg::CHAR_B);
    push_byte(upcp_pkg::CHAR_9); push_byte(upcp_pkg::CHAR_SPACE);
    push_byte(8'h00); push_byte(8'hFF);
    while (byte_q.size() != 0) @(posedge clk);

    run_phase(0, 0, 400, 1'b0);
    run_phase(88, 0, 250, 1'b0);
    run_phase(0, 88, 250, 1'b0);
    run_phase(20, 20, 300, 1'b0);
    run_phase(0, 0, 200, 1'b1);
    run_phase(0, 0, 150, 1'b0);

    while (byte_q.size() != 0 || rx_valid) @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("** uart_pwm_command_parser_top: PASSED **");
    end else begin
      $display("** uart_pwm_command_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
